FILE: design/skpd_pkg.sv
// Shared types, constants and register codes for the keyboard position deframer.
package skpd_pkg;

  localparam int unsigned BufferDepth = 16;
  localparam int unsigned CntW        = $clog2(BufferDepth + 1);
  localparam int unsigned IdxW        = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;

  localparam int unsigned OpW      = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned PosW     = 8;
  localparam int unsigned SmpW     = 6;
  localparam int unsigned UsedOutW = 5;

  // input operation codes
  localparam logic [OpW-1:0] OP_EDGE   = 2'd0;
  localparam logic [OpW-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OpW-1:0] OP_RESYNC = 2'd2;
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SAMPLES_PER_BIT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HIGH_THRESHOLD  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WRAP_POSITION   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_FRAME_LENGTH    = 2'd3;

  // configuration reset values
  localparam logic [SmpW-1:0] RstSamplesPerBit = 6'd50;
  localparam logic [SmpW-1:0] RstHighThreshold = 6'd40;
  localparam logic [PosW-1:0] RstWrapPosition  = 8'd124;
  localparam logic [PosW-1:0] RstFrameLength   = 8'd128;

  typedef struct packed {
    logic [SmpW-1:0] samples_per_bit;
    logic [SmpW-1:0] high_threshold;
    logic [PosW-1:0] wrap_position;
    logic [PosW-1:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic [SmpW-1:0] sample_count;
    logic [SmpW-1:0] high_count;
    logic            window_open;
    logic            syncing;
    logic [CntW-1:0] used_count;
  } state_t;

  typedef struct packed {
    logic                key_valid;
    logic [PosW-1:0]     key_index;
    logic                key_stored;
    logic                frame_wrap;
    logic                desync_error;
    logic                reset_pulse;
    logic                in_sync;
    logic [UsedOutW-1:0] buffer_used;
  } result_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [PosW-1:0] data;
  } store_wr_t;

endpackage

FILE: design/skpd_step.sv
// Next-state and result logic for one input beat of the deframer.
module skpd_step (
  input  skpd_pkg::cfg_t              cfg_i,
  input  skpd_pkg::state_t            state_i,
  input  logic [skpd_pkg::OpW-1:0]    op_i,
  input  logic                        data_level_i,
  output skpd_pkg::state_t            state_o,
  output skpd_pkg::result_t           result_o,
  output skpd_pkg::store_wr_t         store_wr_o
);

  logic [skpd_pkg::SmpW-1:0] need;
  logic [skpd_pkg::SmpW-1:0] high_inc;
  logic [skpd_pkg::SmpW-1:0] samp_inc;
  logic [skpd_pkg::PosW-1:0] pos_base;
  logic                      edge_desync;
  logic                      room;

  assign need        = (cfg_i.samples_per_bit == '0) ? skpd_pkg::SmpW'(1) : cfg_i.samples_per_bit;
  assign high_inc    = state_i.high_count + skpd_pkg::SmpW'(data_level_i);
  assign samp_inc    = state_i.sample_count + skpd_pkg::SmpW'(1);
  assign edge_desync = !state_i.syncing && (state_i.position > cfg_i.frame_length);
  assign pos_base    = edge_desync ? '0 : state_i.position;
  assign room        = state_i.used_count < skpd_pkg::CntW'(skpd_pkg::BufferDepth);

  always_comb begin
    state_o    = state_i;
    result_o   = '0;
    store_wr_o = '0;
    store_wr_o.addr = state_i.used_count[skpd_pkg::IdxW-1:0];
    store_wr_o.data = state_i.position;

    unique case (op_i)
      skpd_pkg::OP_EDGE: begin
        // an edge drops any unfinished window
        if (edge_desync) begin
          state_o.syncing      = 1'b1;
          state_o.used_count   = '0;
          result_o.desync_error = 1'b1;
          result_o.reset_pulse  = 1'b1;
        end
        state_o.position     = pos_base + skpd_pkg::PosW'(1);
        state_o.window_open  = 1'b1;
        state_o.sample_count = '0;
        state_o.high_count   = '0;
      end
      skpd_pkg::OP_SAMPLE: begin
        if (state_i.window_open) begin
          if (state_i.syncing) begin
            // only the first sample after an edge counts in sync mode
            state_o.window_open = 1'b0;
            if (data_level_i) begin
              if (state_i.position == cfg_i.frame_length) begin
                state_o.syncing = 1'b0;
              end
              state_o.position = '0;
            end
          end else if (samp_inc >= need) begin
            state_o.window_open  = 1'b0;
            state_o.sample_count = '0;
            state_o.high_count   = '0;
            if (high_inc >= cfg_i.high_threshold) begin
              if (state_i.position >= cfg_i.wrap_position) begin
                state_o.position    = '0;
                state_o.used_count  = '0;
                result_o.frame_wrap = 1'b1;
              end else begin
                result_o.key_valid = 1'b1;
                result_o.key_index = state_i.position;
                if (room) begin
                  store_wr_o.en       = 1'b1;
                  state_o.used_count  = state_i.used_count + skpd_pkg::CntW'(1);
                  result_o.key_stored = 1'b1;
                end
              end
            end
            if (state_o.position > cfg_i.frame_length) begin
              state_o.position      = '0;
              state_o.used_count    = '0;
              state_o.syncing       = 1'b1;
              result_o.desync_error = 1'b1;
              result_o.reset_pulse  = 1'b1;
            end
          end else begin
            state_o.sample_count = samp_inc;
            state_o.high_count   = high_inc;
          end
        end
      end
      skpd_pkg::OP_RESYNC: begin
        state_o.position     = '0;
        state_o.used_count   = '0;
        state_o.window_open  = 1'b0;
        state_o.sample_count = '0;
        state_o.high_count   = '0;
        state_o.syncing      = 1'b1;
        result_o.reset_pulse = 1'b1;
      end
      skpd_pkg::OP_UNUSED: begin
      end
      default: begin
      end
    endcase

    result_o.in_sync     = !state_o.syncing;
    result_o.buffer_used = skpd_pkg::UsedOutW'(state_o.used_count);
  end

endmodule

FILE: design/scan_keyboard_position_deframer.sv
// Top level of the scanned keyboard position deframer: registers, key buffer, handshakes.
//
// Takes one event beat per clock unless in_stall_o is high (falling edge, line sample
// or forced resync) and returns exactly one result beat for each. An input register
// feeds a single step of compare and counter logic, which updates the scan state and
// loads the result register in the same cycle, so with out_stall_i low the sustained
// rate is one beat per cycle; a beat passes the input, then the result register. The
// result register and the input register together decouple the two sides: a new beat
// is taken while a finished result waits, and out_stall_i backs up to in_stall_o only
// when both are full. Detected keys are written into a 16-entry key buffer; a frame
// wrap, desync or resync empties it by clearing the fill count. The block starts in
// sync mode. Configuration writes are always ready and must only be issued while idle.
module scan_keyboard_position_deframer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [skpd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [skpd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [skpd_pkg::OpW-1:0]        op_i,
  input  logic                            data_level_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            key_valid_o,
  output logic [skpd_pkg::PosW-1:0]       key_index_o,
  output logic                            key_stored_o,
  output logic                            frame_wrap_o,
  output logic                            desync_error_o,
  output logic                            reset_pulse_o,
  output logic                            in_sync_o,
  output logic [skpd_pkg::UsedOutW-1:0]   buffer_used_o
);

  skpd_pkg::cfg_t      cfg_q;
  skpd_pkg::state_t    state_q, state_d;
  skpd_pkg::result_t   result_q, result_d;
  skpd_pkg::store_wr_t store_wr;

  logic                       in_vld_q;
  logic [skpd_pkg::OpW-1:0]   op_q;
  logic                       level_q;
  logic                       out_vld_q;
  logic                       advance;
  logic                       in_take;

  logic [skpd_pkg::PosW-1:0]  key_store_q [skpd_pkg::BufferDepth];

  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.samples_per_bit <= skpd_pkg::RstSamplesPerBit;
      cfg_q.high_threshold  <= skpd_pkg::RstHighThreshold;
      cfg_q.wrap_position   <= skpd_pkg::RstWrapPosition;
      cfg_q.frame_length    <= skpd_pkg::RstFrameLength;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        skpd_pkg::REG_SAMPLES_PER_BIT: cfg_q.samples_per_bit <= cfg_data_i[skpd_pkg::SmpW-1:0];
        skpd_pkg::REG_HIGH_THRESHOLD:  cfg_q.high_threshold  <= cfg_data_i[skpd_pkg::SmpW-1:0];
        skpd_pkg::REG_WRAP_POSITION:   cfg_q.wrap_position   <= cfg_data_i;
        skpd_pkg::REG_FRAME_LENGTH:    cfg_q.frame_length    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= op_i;
      level_q <= data_level_i;
    end
  end

  skpd_step u_step (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .op_i         (op_q),
    .data_level_i (level_q),
    .state_o      (state_d),
    .result_o     (result_d),
    .store_wr_o   (store_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.position     <= '0;
      state_q.sample_count <= '0;
      state_q.high_count   <= '0;
      state_q.window_open  <= 1'b0;
      state_q.syncing      <= 1'b1;
      state_q.used_count   <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  // key buffer
  always_ff @(posedge clk_i) begin
    if (advance && store_wr.en) begin
      key_store_q[store_wr.addr] <= store_wr.data;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign key_valid_o    = result_q.key_valid;
  assign key_index_o    = result_q.key_index;
  assign key_stored_o   = result_q.key_stored;
  assign frame_wrap_o   = result_q.frame_wrap;
  assign desync_error_o = result_q.desync_error;
  assign reset_pulse_o  = result_q.reset_pulse;
  assign in_sync_o      = result_q.in_sync;
  assign buffer_used_o  = result_q.buffer_used;

endmodule
